// ----- src/rbcd_pkg.sv -----
package rbcd_pkg;

   // Field widths
   localparam int MS_IN_W   = 27;
   localparam int MS_OUT_W  = 28;
   localparam int TIME_IN_W = 23;
   localparam int TIME_W    = 22;
   localparam int DATE_W    = 24;
   localparam int DIV_W     = 16;
   localparam int CNT_W     = 15;
   localparam int SUBS_W    = 10;

   // Register stages from request to the core outputs; one more for the result register
   localparam int CORE_STAGES = 7;

   // Reset values of the control registers
   localparam logic [DIV_W-1:0] DIVIDER_RESET = 16'd256;
   localparam logic             SUBS_EN_RESET = 1'b1;

   // Exact reciprocals: floor(n / d) == (n * RECIP) >> SHIFT over the used range
   localparam logic [30:0] RECIP_1000 = 31'd1099511628;   // shift 40, n < 2^27
   localparam logic [20:0] RECIP_3600 = 21'd1193047;      // shift 32, n < 2^18
   localparam logic [26:0] RECIP_60   = 27'd71582789;     // shift 32, n < 2^18
   localparam logic [15:0] RECIP_10   = 16'd205;          // shift 11, n < 1024

   // Millisecond weights of the BCD time digits
   localparam logic [MS_OUT_W-1:0] MS_HOUR_TENS = 28'd36000000;
   localparam logic [MS_OUT_W-1:0] MS_HOUR      = 28'd3600000;
   localparam logic [MS_OUT_W-1:0] MS_MIN_TENS  = 28'd600000;
   localparam logic [MS_OUT_W-1:0] MS_MIN       = 28'd60000;
   localparam logic [MS_OUT_W-1:0] MS_SEC_TENS  = 28'd10000;
   localparam logic [MS_OUT_W-1:0] MS_SEC       = 28'd1000;

   typedef enum logic [0:0] {
      CSR_DIVIDER = 1'b0,
      CSR_SUBS_EN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DIV_W-1:0] divider;
      logic             subs_en;
   } csr_type;

   typedef struct packed {
      logic [MS_OUT_W-1:0] ms_base;
      logic [7:0]          year;
      logic [4:0]          month;
      logic [5:0]          day;
      logic [2:0]          weekday;
   } dec_rec_type;

endpackage

// ----- src/rbcd_enc.sv -----
module rbcd_enc (
   input  logic        clock,
   input  logic [26:0] ms_of_day,
   input  logic [7:0]  year,
   input  logic [3:0]  month,
   input  logic [4:0]  day,
   input  logic [2:0]  weekday,
   output logic [21:0] time_word,
   output logic [23:0] date_word
);
   import rbcd_pkg::*;

   localparam int TIME_DLY = CORE_STAGES - 4;
   localparam int DATE_DLY = CORE_STAGES;

   // Tens digit of a value below 256
   function automatic logic [4:0] tens_of(input logic [7:0] v);
      logic [15:0] p;
      p = 16'(v) * RECIP_10;
      return p[15:11];
   endfunction

   // Stage 1: whole seconds of day, date word
   logic [57:0] prod_1000;
   logic [17:0] sec_n1_in, sec_n1_ff;
   logic [4:0]  yr_t;
   logic [7:0]  yr_rem;
   logic [4:0]  yr_tm;
   logic        mo_hi;
   logic [3:0]  mo_u;
   logic [1:0]  dy_t;
   logic [4:0]  dy_rem;
   logic [23:0] date_in;

   always_comb begin
      prod_1000 = 58'(ms_of_day) * 58'(RECIP_1000);
      sec_n1_in = prod_1000[57:40];

      yr_t   = tens_of(year);
      yr_rem = year - 8'(yr_t) * 8'd10;
      if (yr_t >= 5'd20) begin
         yr_tm = yr_t - 5'd20;
      end else if (yr_t >= 5'd10) begin
         yr_tm = yr_t - 5'd10;
      end else begin
         yr_tm = yr_t;
      end

      mo_hi = (month >= 4'd10);
      mo_u  = mo_hi ? (month - 4'd10) : month;

      if (day >= 5'd30) begin
         dy_t = 2'd3;
      end else if (day >= 5'd20) begin
         dy_t = 2'd2;
      end else if (day >= 5'd10) begin
         dy_t = 2'd1;
      end else begin
         dy_t = 2'd0;
      end
      dy_rem = day - 5'(dy_t) * 5'd10;

      date_in = {yr_tm[3:0], yr_rem[3:0], weekday, mo_hi, mo_u, 2'b00, dy_t, dy_rem[3:0]};
   end

   // Stage 2: hours and whole minutes of day
   logic [38:0] prod_3600;
   logic [44:0] prod_60;
   logic [5:0]  hr2_in, hr2_ff;
   logic [11:0] mt2_in, mt2_ff;
   logic [17:0] sec_n2_ff;

   always_comb begin
      prod_3600 = 39'(sec_n1_ff) * 39'(RECIP_3600);
      prod_60   = 45'(sec_n1_ff) * 45'(RECIP_60);
      hr2_in    = prod_3600[37:32];
      mt2_in    = prod_60[43:32];
   end

   // Stage 3: seconds and minutes within their unit
   logic [17:0] sec_full;
   logic [11:0] min_full;
   logic [5:0]  sec3_ff, min3_ff, hr3_ff;

   always_comb begin
      sec_full = sec_n2_ff - 18'(mt2_ff) * 18'd60;
      min_full = mt2_ff - 12'(hr2_ff) * 12'd60;
   end

   // Stage 4: split into BCD digits
   logic [4:0]  sec_t, min_t, hr_t;
   logic [5:0]  sec_u, min_u, hr_u;
   logic [21:0] time4_in, time4_ff;

   always_comb begin
      sec_t = tens_of(8'(sec3_ff));
      min_t = tens_of(8'(min3_ff));
      hr_t  = tens_of(8'(hr3_ff));
      sec_u = sec3_ff - 6'(sec_t) * 6'd10;
      min_u = min3_ff - 6'(min_t) * 6'd10;
      hr_u  = hr3_ff - 6'(hr_t) * 6'd10;
      time4_in = {hr_t[1:0], hr_u[3:0], 1'b0, min_t[2:0], min_u[3:0],
                  1'b0, sec_t[2:0], sec_u[3:0]};
   end

   // Align both words to the core output stage
   logic [21:0] time_dly_ff [TIME_DLY];
   logic [23:0] date_dly_ff [DATE_DLY];

   always_ff @(posedge clock) begin
      sec_n1_ff <= sec_n1_in;
      hr2_ff    <= hr2_in;
      mt2_ff    <= mt2_in;
      sec_n2_ff <= sec_n1_ff;
      sec3_ff   <= sec_full[5:0];
      min3_ff   <= min_full[5:0];
      hr3_ff    <= hr2_ff;
      time4_ff  <= time4_in;

      time_dly_ff[0] <= time4_ff;
      for (int i = 1; i < TIME_DLY; i++) begin
         time_dly_ff[i] <= time_dly_ff[i-1];
      end
      date_dly_ff[0] <= date_in;
      for (int i = 1; i < DATE_DLY; i++) begin
         date_dly_ff[i] <= date_dly_ff[i-1];
      end
   end

   assign time_word = time_dly_ff[TIME_DLY-1];
   assign date_word = date_dly_ff[DATE_DLY-1];

endmodule

// ----- src/rbcd_dec.sv -----
module rbcd_dec (
   input  logic                 clock,
   input  logic [21:0]          time_word,
   input  logic [23:0]          date_word,
   output rbcd_pkg::dec_rec_type rec
);
   import rbcd_pkg::*;

   localparam int REC_DLY = CORE_STAGES - 2;

   // Stage 1: weight the time digits, decode the date fields
   logic [MS_OUT_W-1:0] hr_part_in, min_part_in, sec_part_in;
   logic [MS_OUT_W-1:0] hr_part_ff, min_part_ff, sec_part_ff;
   logic [7:0]          year_in, year_ff;
   logic [4:0]          month_in, month_ff;
   logic [5:0]          day_in, day_ff;
   logic [2:0]          wk_ff;

   always_comb begin
      hr_part_in  = 28'(time_word[21:20]) * MS_HOUR_TENS
                  + 28'(time_word[19:16]) * MS_HOUR;
      min_part_in = 28'(time_word[14:12]) * MS_MIN_TENS
                  + 28'(time_word[11:8]) * MS_MIN;
      sec_part_in = 28'(time_word[6:4]) * MS_SEC_TENS
                  + 28'(time_word[3:0]) * MS_SEC;
      year_in  = 8'(date_word[23:20]) * 8'd10 + 8'(date_word[19:16]);
      month_in = 5'(date_word[12]) * 5'd10 + 5'(date_word[11:8]);
      day_in   = 6'(date_word[5:4]) * 6'd10 + 6'(date_word[3:0]);
   end

   // Stage 2: total the time parts
   dec_rec_type rec2_in, rec2_ff;

   always_comb begin
      rec2_in.ms_base = hr_part_ff + min_part_ff + sec_part_ff;
      rec2_in.year    = year_ff;
      rec2_in.month   = month_ff;
      rec2_in.day     = day_ff;
      rec2_in.weekday = wk_ff;
   end

   dec_rec_type rec_dly_ff [REC_DLY];

   always_ff @(posedge clock) begin
      hr_part_ff  <= hr_part_in;
      min_part_ff <= min_part_in;
      sec_part_ff <= sec_part_in;
      year_ff     <= year_in;
      month_ff    <= month_in;
      day_ff      <= day_in;
      wk_ff       <= date_word[15:13];
      rec2_ff     <= rec2_in;

      // Align to the core output stage
      rec_dly_ff[0] <= rec2_ff;
      for (int i = 1; i < REC_DLY; i++) begin
         rec_dly_ff[i] <= rec_dly_ff[i-1];
      end
   end

   assign rec = rec_dly_ff[REC_DLY-1];

endmodule

// ----- src/rbcd_div.sv -----
module rbcd_div (
   input  logic             clock,
   input  rbcd_pkg::csr_type csr,
   input  logic [14:0]      count,
   output logic [9:0]       subs_ms
);
   import rbcd_pkg::*;

   // Two quotient bits per stage
   localparam int DIV_STAGES = SUBS_W / 2;

   // One restoring step: {quotient bit, new remainder}
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [DIV_W-1:0] dvs);
      logic [DIV_W:0] sh;
      sh = {rem, bit_in};
      if (sh >= {1'b0, dvs}) begin
         return {1'b1, DIV_W'(sh - {1'b0, dvs})};
      end else begin
         return {1'b0, sh[DIV_W-1:0]};
      end
   endfunction

   // Stage 1: remaining prescaler ticks, qualify the count
   logic             ok1_in, ok1_ff;
   logic [DIV_W-1:0] ticks_in, ticks_ff;

   always_comb begin
      ok1_in   = csr.subs_en && (csr.divider != '0) && ({1'b0, count} < csr.divider);
      ticks_in = csr.divider - 16'd1 - 16'(count);
   end

   // Stage 2: scale to milliseconds and seed the divider
   logic [25:0] dvd;

   assign dvd = 26'(ticks_ff) * 26'd1000;

   // Divider stages, quotient below 1000 so the top dividend bits start below the divisor
   logic [DIV_W-1:0]  rem_ff [DIV_STAGES+1];
   logic [SUBS_W-1:0] low_ff [DIV_STAGES+1];
   logic [SUBS_W-1:0] quo_ff [DIV_STAGES+1];
   logic              ok_ff  [DIV_STAGES+1];
   logic [DIV_W-1:0]  rem_in [DIV_STAGES];
   logic [SUBS_W-1:0] low_in [DIV_STAGES];
   logic [SUBS_W-1:0] quo_in [DIV_STAGES];

   always_comb begin
      logic [DIV_W:0] step_a;
      logic [DIV_W:0] step_b;
      for (int j = 0; j < DIV_STAGES; j++) begin
         step_a    = div_step(rem_ff[j], low_ff[j][SUBS_W-1], csr.divider);
         step_b    = div_step(step_a[DIV_W-1:0], low_ff[j][SUBS_W-2], csr.divider);
         rem_in[j] = step_b[DIV_W-1:0];
         low_in[j] = {low_ff[j][SUBS_W-3:0], 2'b00};
         quo_in[j] = {quo_ff[j][SUBS_W-3:0], step_a[DIV_W], step_b[DIV_W]};
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff   <= ok1_in;
      ticks_ff <= ticks_in;

      rem_ff[0] <= dvd[25:SUBS_W];
      low_ff[0] <= dvd[SUBS_W-1:0];
      quo_ff[0] <= '0;
      ok_ff[0]  <= ok1_ff;
      for (int j = 0; j < DIV_STAGES; j++) begin
         rem_ff[j+1] <= rem_in[j];
         low_ff[j+1] <= low_in[j];
         quo_ff[j+1] <= quo_in[j];
         ok_ff[j+1]  <= ok_ff[j];
      end
   end

   // Drop the fraction when disabled or the count is out of range
   assign subs_ms = ok_ff[DIV_STAGES] ? quo_ff[DIV_STAGES] : '0;

endmodule

// ----- src/rtc_bcd_time_date_codec_core.sv -----
// BCD time/date codec for a real-time clock calendar.
// Request channel: drive the request fields and raise start; a request is taken
// at every rising edge with start high and busy low. busy stays low, so a new
// request can be issued in every cycle.
// req_op = 0 packs the binary record into BCD time and date words; req_op = 1
// weights the BCD words back to milliseconds of day and calendar fields, adding
// the sub-second fraction from the prescaler when enabled.
// Result channel: rsp_valid is high for exactly one cycle with the result on the
// rsp_ ports, in request order.
// One result per request, one per cycle at full rate. The receiver cannot stall.
// The pipeline depth follows the sub-second divider: a 10-bit quotient retired two
// bits per stage behind two setup stages, plus the result register.
// Control registers are written over the csr_ port (always ready): index 0 the
// prescaler value, index 1 the sub-second enable. Write them only while no
// request is in flight.
// Reset (synchronous) clears the pipeline valid bits and sets the prescaler
// to 256 with sub-seconds enabled.
module rtc_bcd_time_date_codec_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_op,
   input  logic [26:0]                req_ms_of_day_in,
   input  logic [7:0]                 req_year_in,
   input  logic [3:0]                 req_month_in,
   input  logic [4:0]                 req_day_in,
   input  logic [2:0]                 req_weekday_in,
   input  logic                       req_dst_in,
   input  logic [22:0]                req_time_word_in,
   input  logic [23:0]                req_date_word_in,
   input  logic [14:0]                req_subsecond_count,
   output logic                       rsp_valid,
   output logic [21:0]                rsp_time_word_out,
   output logic [23:0]                rsp_date_word_out,
   output logic [27:0]                rsp_ms_of_day_out,
   output logic [7:0]                 rsp_year_out,
   output logic [4:0]                 rsp_month_out,
   output logic [5:0]                 rsp_day_out,
   output logic [2:0]                 rsp_weekday_out,
   output logic                       rsp_dst_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  rbcd_pkg::csr_index_type    csr_index,
   input  logic [15:0]                csr_wdata
);
   import rbcd_pkg::*;

   logic req_fire;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign req_fire  = start & ~busy;

   // Control registers
   csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.divider <= DIVIDER_RESET;
         csr_ff.subs_en <= SUBS_EN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIVIDER: csr_ff.divider <= csr_wdata;
            CSR_SUBS_EN: csr_ff.subs_en <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Datapath units
   logic [21:0]  enc_time;
   logic [23:0]  enc_date;
   dec_rec_type  dec_rec;
   logic [9:0]   subs_ms;

   rbcd_enc u_enc (
      .clock     (clock),
      .ms_of_day (req_ms_of_day_in),
      .year      (req_year_in),
      .month     (req_month_in),
      .day       (req_day_in),
      .weekday   (req_weekday_in),
      .time_word (enc_time),
      .date_word (enc_date)
   );

   rbcd_dec u_dec (
      .clock     (clock),
      .time_word (req_time_word_in[21:0]),
      .date_word (req_date_word_in),
      .rec       (dec_rec)
   );

   rbcd_div u_div (
      .clock   (clock),
      .csr     (csr_ff),
      .count   (req_subsecond_count),
      .subs_ms (subs_ms)
   );

   // Carry valid, op and dst alongside the datapath
   logic vld_ff [CORE_STAGES];
   logic op_ff  [CORE_STAGES];
   logic dst_ff [CORE_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORE_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= req_fire;
         for (int i = 1; i < CORE_STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff[0]  <= req_op;
      dst_ff[0] <= req_dst_in;
      for (int i = 1; i < CORE_STAGES; i++) begin
         op_ff[i]  <= op_ff[i-1];
         dst_ff[i] <= dst_ff[i-1];
      end
   end

   // Result stage: select by direction, zero the unused side
   logic              op_last;
   logic [27:0]       ms_sum;
   logic              rsp_valid_ff;
   logic [21:0]       time_out_ff;
   logic [23:0]       date_out_ff;
   logic [27:0]       ms_out_ff;
   logic [7:0]        year_out_ff;
   logic [4:0]        month_out_ff;
   logic [5:0]        day_out_ff;
   logic [2:0]        wk_out_ff;
   logic              dst_out_ff;

   assign op_last = op_ff[CORE_STAGES-1];
   assign ms_sum  = dec_rec.ms_base + 28'(subs_ms);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[CORE_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      time_out_ff  <= op_last ? '0 : enc_time;
      date_out_ff  <= op_last ? '0 : enc_date;
      ms_out_ff    <= op_last ? ms_sum : '0;
      year_out_ff  <= op_last ? dec_rec.year : '0;
      month_out_ff <= op_last ? dec_rec.month : '0;
      day_out_ff   <= op_last ? dec_rec.day : '0;
      wk_out_ff    <= op_last ? dec_rec.weekday : '0;
      dst_out_ff   <= dst_ff[CORE_STAGES-1];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_time_word_out = time_out_ff;
   assign rsp_date_word_out = date_out_ff;
   assign rsp_ms_of_day_out = ms_out_ff;
   assign rsp_year_out      = year_out_ff;
   assign rsp_month_out     = month_out_ff;
   assign rsp_day_out       = day_out_ff;
   assign rsp_weekday_out   = wk_out_ff;
   assign rsp_dst_out       = dst_out_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   import rbcd_pkg::*;

   typedef struct packed {
      logic                 op;
      logic [MS_IN_W-1:0]   ms;
      logic [7:0]           year;
      logic [3:0]           month;
      logic [4:0]           day;
      logic [2:0]           weekday;
      logic                 dst;
      logic [TIME_IN_W-1:0] time_word;
      logic [DATE_W-1:0]    date_word;
      logic [CNT_W-1:0]     count;
   } calendar_req_type;

   typedef struct packed {
      logic [TIME_W-1:0]   time_word;
      logic [DATE_W-1:0]   date_word;
      logic [MS_OUT_W-1:0] ms;
      logic [7:0]          year;
      logic [4:0]          month;
      logic [5:0]          day;
      logic [2:0]          weekday;
      logic                dst;
   } calendar_rsp_type;

   localparam int NUM_PHASES = 7;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = 1'b0;
   logic [26:0]           req_ms_of_day_in = '0;
   logic [7:0]            req_year_in = '0;
   logic [3:0]            req_month_in = '0;
   logic [4:0]            req_day_in = '0;
   logic [2:0]            req_weekday_in = '0;
   logic                  req_dst_in = 1'b0;
   logic [22:0]           req_time_word_in = '0;
   logic [23:0]           req_date_word_in = '0;
   logic [14:0]           req_subsecond_count = '0;
   logic                  rsp_valid;
   logic [21:0]           rsp_time_word_out;
   logic [23:0]           rsp_date_word_out;
   logic [27:0]           rsp_ms_of_day_out;
   logic [7:0]            rsp_year_out;
   logic [4:0]            rsp_month_out;
   logic [5:0]            rsp_day_out;
   logic [2:0]            rsp_weekday_out;
   logic                  rsp_dst_out;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_DIVIDER;
   logic [15:0]           csr_wdata = '0;

   // Testbench state
   calendar_req_type pending_req_q[$];
   calendar_rsp_type expected_rsp_q[$];
   logic [DIV_W-1:0] divider_copy = DIVIDER_RESET;
   logic             subs_en_copy = SUBS_EN_RESET;
   logic             req_fire = 1'b0;
   logic             csr_fire = 1'b0;
   bit               gaps_on = 1'b1;
   int               idle_cycles = 0;
   int               mismatches = 0;

   rtc_bcd_time_date_codec_core u_dut (.*);

   always #10 clock = ~clock;

   // Split a value into two BCD digits, tens digit taken mod 10
   function automatic logic [7:0] bcd_pair(logic [31:0] n);
      return {4'((n / 10) % 10), 4'(n % 10)};
   endfunction

   // Compute the converted record for one request
   function automatic calendar_rsp_type convert_record(calendar_req_type rq,
                                                       logic [DIV_W-1:0] div,
                                                       logic subs_en);
      calendar_rsp_type rs;
      logic [31:0]   n;
      logic [31:0]   tw;
      logic [31:0]   dw;
      logic [31:0]   ms_sum;
      logic [31:0]   d;
      logic [31:0]   c;
      rs = '0;
      rs.dst = rq.dst;
      if (rq.op == 1'b0) begin
         // Encode: whole seconds into BCD, sub-seconds dropped
         n = rq.ms / 1000;
         tw = n % 10;
         n = n / 10;
         tw |= (n % 6) << 4;
         n = n / 6;
         tw |= (n % 10) << 8;
         n = n / 10;
         tw |= (n % 6) << 12;
         n = n / 6;
         tw |= (n % 10) << 16;
         n = n / 10;
         tw |= (n & 3) << 20;
         dw = (bcd_pair(rq.year) << 16) | (bcd_pair(rq.month) << 8) | bcd_pair(rq.day);
         dw |= rq.weekday << 13;
         rs.time_word = tw[TIME_W-1:0];
         rs.date_word = dw[DATE_W-1:0];
      end else begin
         // Decode: weight each nibble as is after the field masks
         ms_sum = rq.time_word[21:20] * MS_HOUR_TENS;
         ms_sum += rq.time_word[19:16] * MS_HOUR;
         ms_sum += rq.time_word[14:12] * MS_MIN_TENS;
         ms_sum += rq.time_word[11:8] * MS_MIN;
         ms_sum += rq.time_word[6:4] * MS_SEC_TENS;
         ms_sum += rq.time_word[3:0] * MS_SEC;
         d = div;
         c = rq.count;
         // Sub-second part is zero when disabled, divider zero or count not below divider
         if (subs_en && d != 0 && c <= d - 1)
            ms_sum += ((d - 1 - c) * 1000) / d;
         rs.ms = ms_sum[MS_OUT_W-1:0];
         rs.year = 8'(rq.date_word[23:20] * 10 + rq.date_word[19:16]);
         rs.month = 5'(rq.date_word[12] * 10 + rq.date_word[11:8]);
         rs.day = 6'(rq.date_word[5:4] * 10 + rq.date_word[3:0]);
         rs.weekday = rq.date_word[15:13];
      end
      return rs;
   endfunction

   function automatic calendar_req_type make_req(logic op, logic [31:0] ms, logic [7:0] year,
                                                 logic [3:0] month, logic [4:0] day,
                                                 logic [2:0] weekday, logic dst,
                                                 logic [22:0] tw, logic [23:0] dw,
                                                 logic [14:0] count);
      calendar_req_type rq;
      rq.op = op;
      rq.ms = ms[MS_IN_W-1:0];
      rq.year = year;
      rq.month = month;
      rq.day = day;
      rq.weekday = weekday;
      rq.dst = dst;
      rq.time_word = tw;
      rq.date_word = dw;
      rq.count = count;
      return rq;
   endfunction

   // Mostly calendar-valid requests, some with arbitrary bits
   function automatic calendar_req_type random_request(logic [DIV_W-1:0] div);
      calendar_req_type rq;
      logic [31:0]   hi;
      int unsigned   h, m, s, yr, mo, dy;
      rq.op = 1'($urandom_range(0, 1));
      rq.dst = 1'($urandom_range(0, 1));
      rq.weekday = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 85) begin
         rq.ms = 27'($urandom_range(0, 86399999));
         rq.year = 8'($urandom_range(0, 99));
         rq.month = 4'($urandom_range(1, 12));
         rq.day = 5'($urandom_range(1, 31));
      end else begin
         rq.ms = 27'($urandom());
         rq.year = 8'($urandom());
         rq.month = 4'($urandom());
         rq.day = 5'($urandom());
      end
      if ($urandom_range(0, 99) < 85) begin
         h = $urandom_range(0, 23);
         m = $urandom_range(0, 59);
         s = $urandom_range(0, 59);
         yr = $urandom_range(0, 99);
         mo = $urandom_range(1, 12);
         dy = $urandom_range(1, 31);
         rq.time_word = {1'($urandom_range(0, 1)), 2'(h / 10), 4'(h % 10), 1'b0,
                         3'(m / 10), 4'(m % 10), 1'b0, 3'(s / 10), 4'(s % 10)};
         rq.date_word = {4'(yr / 10), 4'(yr % 10), rq.weekday, 1'(mo / 10), 4'(mo % 10),
                         2'b00, 2'(dy / 10), 4'(dy % 10)};
      end else begin
         rq.time_word = 23'($urandom());
         rq.date_word = 24'($urandom());
      end
      // Keep most counts inside the divider range, probe its edge, then noise
      hi = (div == 0) ? 0 : div - 1;
      if (hi > 32767)
         hi = 32767;
      case ($urandom_range(0, 9))
         0: rq.count = 15'($urandom());
         1: rq.count = (hi + $urandom_range(0, 2) > 32767) ? 15'h7FFF
                                                          : 15'(hi + $urandom_range(0, 2));
         default: rq.count = 15'($urandom_range(0, hi));
      endcase
      return rq;
   endfunction

   task automatic add_random(int num, logic [DIV_W-1:0] div);
      repeat (num) pending_req_q.push_back(random_request(div));
   endtask

   // Hold until every queued request is taken and every result is back
   task automatic wait_drained();
      while (pending_req_q.size() != 0 || start || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (CORE_STAGES + 3) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Drive requests at the falling edge, hold while not taken
   always @(negedge clock) begin : driver
      calendar_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_fire) begin
         if (idle_cycles > 0) begin
            idle_cycles--;
            start <= 1'b0;
         end else if (pending_req_q.size() > 0) begin
            nxt = pending_req_q.pop_front();
            start <= 1'b1;
            req_op <= nxt.op;
            req_ms_of_day_in <= nxt.ms;
            req_year_in <= nxt.year;
            req_month_in <= nxt.month;
            req_day_in <= nxt.day;
            req_weekday_in <= nxt.weekday;
            req_dst_in <= nxt.dst;
            req_time_word_in <= nxt.time_word;
            req_date_word_in <= nxt.date_word;
            req_subsecond_count <= nxt.count;
            if (gaps_on && $urandom_range(0, 5) == 0)
               idle_cycles = $urandom_range(1, 15);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Track handshakes and register writes, predict and check results
   always @(posedge clock) begin : monitor
      calendar_req_type seen;
      calendar_rsp_type want;
      req_fire <= !reset && start && !busy;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (reset) begin
         divider_copy <= DIVIDER_RESET;
         subs_en_copy <= SUBS_EN_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIVIDER: divider_copy <= csr_wdata;
               CSR_SUBS_EN: subs_en_copy <= csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            seen = make_req(req_op, 32'(req_ms_of_day_in), req_year_in, req_month_in,
                            req_day_in, req_weekday_in, req_dst_in, req_time_word_in,
                            req_date_word_in, req_subsecond_count);
            expected_rsp_q.push_back(convert_record(seen, divider_copy, subs_en_copy));
         end
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: result expected none, got time %h date %h ms %0d", $time,
                        rsp_time_word_out, rsp_date_word_out, rsp_ms_of_day_out);
               mismatches++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("time_word_out", want.time_word, rsp_time_word_out);
               check_field("date_word_out", want.date_word, rsp_date_word_out);
               check_field("ms_of_day_out", want.ms, rsp_ms_of_day_out);
               check_field("year_out", want.year, rsp_year_out);
               check_field("month_out", want.month, rsp_month_out);
               check_field("day_out", want.day, rsp_day_out);
               check_field("weekday_out", want.weekday, rsp_weekday_out);
               check_field("dst_out", want.dst, rsp_dst_out);
            end
         end
      end
   end

   initial begin : stimulus
      logic [15:0] phase_div[NUM_PHASES];
      logic        phase_en[NUM_PHASES];
      phase_div = '{16'd1, 16'd32768, 16'd0, 16'd65535, 16'd1000, 16'd3, 16'd256};
      phase_en = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings
      pending_req_q.push_back(make_req(0, 0, 0, 1, 1, 0, 0, 0, 0, 0));
      pending_req_q.push_back(make_req(0, 86399999, 99, 12, 31, 7, 1, 0, 0, 0));
      pending_req_q.push_back(make_req(0, 32'h7FFFFFF, 255, 15, 31, 7, 1,
                                       23'h7FFFFF, 24'hFFFFFF, 15'h7FFF));
      pending_req_q.push_back(make_req(0, 45296789, 25, 10, 0, 3, 0, 0, 0, 0));
      pending_req_q.push_back(make_req(0, 999, 100, 0, 9, 5, 1, 0, 0, 0));
      pending_req_q.push_back(make_req(0, 1000, 9, 9, 10, 2, 0, 0, 0, 0));
      pending_req_q.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 23'h000000, 24'h000000, 0));
      pending_req_q.push_back(make_req(1, 0, 0, 0, 0, 0, 1, 23'h235959, 24'h99F231, 255));
      pending_req_q.push_back(make_req(1, 32'h7FFFFFF, 255, 15, 31, 7, 0,
                                       23'h7FFFFF, 24'hFFFFFF, 256));
      pending_req_q.push_back(make_req(1, 0, 0, 0, 0, 0, 1, 23'h400000, 24'h000000, 15'h7FFF));
      pending_req_q.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 23'h3F7F7F, 24'hFFE03F, 128));
      pending_req_q.push_back(make_req(1, 0, 0, 0, 0, 0, 1, 23'h000001, 24'h010101, 1));
      add_random(200, DIVIDER_RESET);
      wait_drained();

      // Walk through divider and enable settings, extremes included
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_DIVIDER, phase_div[p]);
         write_csr(CSR_SUBS_EN, 16'(phase_en[p]));
         if (p == NUM_PHASES - 1)
            gaps_on = 1'b0;
         add_random(90, phase_div[p]);
         wait_drained();
         add_random(80, phase_div[p]);
         wait_drained();
      end

      if (mismatches == 0 && expected_rsp_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- rtc_bcd_time_date_codec_core.f -----
src/rbcd_pkg.sv
src/rbcd_enc.sv
src/rbcd_dec.sv
src/rbcd_div.sv
src/rtc_bcd_time_date_codec_core.sv
tb/tb_top.sv
